// File: design/gai_pkg.sv
// ----------------------------------------------------------------------------
// gai_pkg
// shared types, constants and the microcode table of the gyro angle integrator
// ----------------------------------------------------------------------------
`default_nettype none

package gai_pkg;

    // register indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_ALPHA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_WEIGHT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_BIAS    = 3'd4;

    // register reset values
    localparam logic [15:0] RST_SAMPLE_PERIOD   = 16'd655;
    localparam logic [15:0] RST_SMOOTHING_ALPHA = 16'd62259;
    localparam logic [14:0] RST_STILL_THRESHOLD = 15'd82;
    localparam logic [15:0] RST_BIAS_WEIGHT     = 16'd655;
    localparam logic [15:0] RST_INITIAL_BIAS    = 16'd0;

    // datapath widths
    localparam int OPA_W  = 33;            // rate difference / angle gap
    localparam int MB_W   = 18;            // signed second multiplier operand
    localparam int PROD_W = OPA_W + MB_W;
    localparam int SUM_W  = 36;            // widened accumulate before saturation
    localparam int STEP_W = 4;

    // action codes
    localparam logic ACT_SAMPLE  = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef enum logic [1:0] {
        B_PERIOD,
        B_WEIGHT,
        B_GAIN
    } t_bsel;

    typedef enum logic [1:0] {
        J_NONE,
        J_RESTART,
        J_NOT_STILL
    } t_jcond;

    typedef struct packed {
        logic              ld_diff;
        logic              ld_gap;
        logic              mul;
        t_bsel             bsel;
        logic              upd_angle;
        logic              upd_bias;
        logic              upd_smooth;
        logic              clr;
        t_jcond            jcond;
        logic [STEP_W-1:0] target;
        logic              done;
    } t_ctrl;

    // microcode addresses
    localparam logic [STEP_W-1:0] UA_DIFF    = 4'd0;
    localparam logic [STEP_W-1:0] UA_MUL_PER = 4'd1;
    localparam logic [STEP_W-1:0] UA_ANGLE   = 4'd2;
    localparam logic [STEP_W-1:0] UA_MUL_WT  = 4'd3;
    localparam logic [STEP_W-1:0] UA_BIAS    = 4'd4;
    localparam logic [STEP_W-1:0] UA_GAP     = 4'd5;
    localparam logic [STEP_W-1:0] UA_MUL_GN  = 4'd6;
    localparam logic [STEP_W-1:0] UA_SMOOTH  = 4'd7;
    localparam logic [STEP_W-1:0] UA_CLEAR   = 4'd8;

    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl cw;
        cw = '0;
        case (step)
            UA_DIFF: begin
                cw.ld_diff = 1'b1;
                cw.jcond   = J_RESTART;
                cw.target  = UA_CLEAR;
            end
            UA_MUL_PER: begin
                cw.mul  = 1'b1;
                cw.bsel = B_PERIOD;
            end
            UA_ANGLE: begin
                cw.upd_angle = 1'b1;
            end
            UA_MUL_WT: begin
                cw.mul    = 1'b1;
                cw.bsel   = B_WEIGHT;
                cw.jcond  = J_NOT_STILL;
                cw.target = UA_GAP;
            end
            UA_BIAS: begin
                cw.upd_bias = 1'b1;
            end
            UA_GAP: begin
                cw.ld_gap = 1'b1;
            end
            UA_MUL_GN: begin
                cw.mul  = 1'b1;
                cw.bsel = B_GAIN;
            end
            UA_SMOOTH: begin
                cw.upd_smooth = 1'b1;
                cw.done       = 1'b1;
            end
            UA_CLEAR: begin
                cw.clr  = 1'b1;
                cw.done = 1'b1;
            end
            default: begin
                cw.done = 1'b1;
            end
        endcase
        return cw;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(64'sh7FFF_FFFF);
        lo = -SUM_W'(64'sh8000_0000);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

// File: design/gyro_angle_integrator_core.sv
// ----------------------------------------------------------------------------
// gyro_angle_integrator_core
// bias-tracking gyro rate integrator with exponential angle smoothing
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_ready     i_action, i_rate_sample
// output    out        o_out_valid / i_out_ready   o_smoothed_angle
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// a sample inside the still band occupies the acceptance cycle plus eight
// microcode steps before the input slot is free again, three of them on the
// one shared 33x18 multiplier; a sample outside the band skips the bias
// step; a restart runs through acceptance, decode and clear. the result is
// written to the output register by the last step.
// reset is synchronous and active low; it clears control state, the three
// filter states and the configuration registers.
// a full output register that is not taken holds the program on its last
// step; the input side reopens as soon as the result is parked.
`default_nettype none

module gyro_angle_integrator_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input transactions
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_action,
    input  wire logic signed [15:0]            i_rate_sample,
    // result transactions
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [31:0]                 o_smoothed_angle,
    // configuration writes
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [gai_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                   i_cfg_data
);
    import gai_pkg::*;

    // configuration registers
    logic [15:0]        r_period;
    logic [15:0]        r_alpha;
    logic [14:0]        r_thresh;
    logic [15:0]        r_weight;
    logic signed [15:0] r_init_bias;

    // sequencer
    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic              r_action;
    logic signed [15:0] r_rate;

    // filter state
    logic signed [31:0] r_angle;
    logic signed [31:0] r_bias;
    logic signed [31:0] r_smooth;

    // datapath
    logic signed [OPA_W-1:0]  r_opa;
    logic signed [PROD_W-1:0] r_prod;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_out_data;

    t_ctrl                   w_cw;
    logic                    w_go;
    logic                    w_jump;
    logic                    w_still;
    logic [OPA_W:0]          w_mag;
    logic signed [OPA_W-1:0] w_diff;
    logic signed [OPA_W-1:0] w_gap;
    logic [16:0]             w_gain;
    logic signed [MB_W-1:0]  w_mb;
    logic signed [31:0]      n_angle;
    logic signed [31:0]      n_bias;
    logic signed [31:0]      n_smooth;

    assign w_cw = ucode(r_step);

    // the last step waits while the previous result is still parked
    assign w_go = r_busy && !(w_cw.done && r_out_valid && !i_out_ready);

    // bias-corrected rate, Q17.16
    assign w_diff = {r_rate[15], r_rate, 16'b0} - OPA_W'(r_bias);
    assign w_gap  = OPA_W'(r_angle) - OPA_W'(r_smooth);

    // stillness test on the difference held in the operand register
    assign w_mag   = r_opa[OPA_W-1] ? -{r_opa[OPA_W-1], r_opa} : {r_opa[OPA_W-1], r_opa};
    assign w_still = w_mag < {3'b000, r_thresh, 16'b0};

    // one minus alpha, unsigned Q1.16
    assign w_gain = 17'h10000 - {1'b0, r_alpha};

    always_comb begin
        case (w_cw.bsel)
            B_PERIOD: w_mb = MB_W'({2'b00, r_period});
            B_WEIGHT: w_mb = MB_W'({2'b00, r_weight});
            B_GAIN:   w_mb = MB_W'({1'b0, w_gain});
            default:  w_mb = '0;
        endcase
    end

    always_comb begin
        case (w_cw.jcond)
            J_RESTART:   w_jump = (r_action == ACT_RESTART);
            J_NOT_STILL: w_jump = !w_still;
            default:     w_jump = 1'b0;
        endcase
    end

    // floor shifts come from the arithmetic right shift of the product
    assign n_angle  = sat32(SUM_W'(r_angle)  + SUM_W'(r_prod >>> 24));
    assign n_bias   = sat32(SUM_W'(r_bias)   + SUM_W'(r_prod >>> 16));
    assign n_smooth = sat32(SUM_W'(r_smooth) + SUM_W'(r_prod >>> 16));

    // configuration port never stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= RST_SAMPLE_PERIOD;
            r_alpha     <= RST_SMOOTHING_ALPHA;
            r_thresh    <= RST_STILL_THRESHOLD;
            r_weight    <= RST_BIAS_WEIGHT;
            r_init_bias <= RST_INITIAL_BIAS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SAMPLE_PERIOD:   r_period    <= i_cfg_data;
                CFG_SMOOTHING_ALPHA: r_alpha     <= i_cfg_data;
                CFG_STILL_THRESHOLD: r_thresh    <= i_cfg_data[14:0];
                CFG_BIAS_WEIGHT:     r_weight    <= i_cfg_data;
                CFG_INITIAL_BIAS:    r_init_bias <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // step counter and conditional jumps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= UA_DIFF;
        end else if (!r_busy) begin
            if (i_in_valid) begin
                r_busy <= 1'b1;
                r_step <= UA_DIFF;
            end
        end else if (w_go) begin
            if (w_cw.done) begin
                r_busy <= 1'b0;
            end else if (w_jump) begin
                r_step <= w_cw.target;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // captured input payload
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_in_valid) begin
            r_action <= i_action;
            r_rate   <= i_rate_sample;
        end
    end

    // operand register and shared multiplier
    always_ff @(posedge i_clk) begin
        if (w_go && w_cw.ld_diff) begin
            r_opa <= w_diff;
        end else if (w_go && w_cw.ld_gap) begin
            r_opa <= w_gap;
        end
        if (w_go && w_cw.mul) begin
            r_prod <= r_opa * w_mb;
        end
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle  <= '0;
            r_bias   <= '0;
            r_smooth <= '0;
        end else if (w_go) begin
            if (w_cw.clr) begin
                r_angle  <= '0;
                r_bias   <= {r_init_bias, 16'b0};
                r_smooth <= '0;
            end
            if (w_cw.upd_angle) begin
                r_angle <= n_angle;
            end
            if (w_cw.upd_bias) begin
                r_bias <= n_bias;
            end
            if (w_cw.upd_smooth) begin
                r_smooth <= n_smooth;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_cw.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_cw.done) begin
            r_out_data <= w_cw.clr ? 32'sd0 : n_smooth;
        end
    end

    assign o_in_ready       = !r_busy;
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_smoothed_angle = r_out_data;

endmodule

`default_nettype wire

// File: design/gai_checker.sv
// ----------------------------------------------------------------------------
// gai_checker
// port-level checks for the gyro angle integrator
// ----------------------------------------------------------------------------
`default_nettype none

module gai_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic signed [31:0]            o_smoothed_angle
);

    // a parked result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transaction");

    // a parked result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_smoothed_angle))
        else $error("result changed while stalled");

    // one item in flight: input closes right after a transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while busy");

    // nothing is shown right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("state not cleared by reset");

endmodule

bind gyro_angle_integrator_core gai_checker u_gai_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_smoothed_angle (o_smoothed_angle)
);

`default_nettype wire
